// File: sv/go_to_goal_steering_defines.svh
// assertion macros for the go-to-goal steering block
// no dependencies; included by files that carry concurrent assertions
`ifndef GO_TO_GOAL_STEERING_DEFINES_SVH
`define GO_TO_GOAL_STEERING_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GTG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define GTG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/gtg_pkg.sv
// shared types, constants and the arctangent table of the steering block
// no dependencies
`default_nettype none

package gtg_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    // field widths
    localparam int DELTA_W = 17;   // goal minus pose, exact
    localparam int DW      = 28;   // cordic x/y datapath
    localparam int ZW      = 24;   // cordic angle, Q3.20

    localparam logic signed [ZW-1:0] ANG_PI   = 24'sd3294199;
    localparam logic [15:0]          INV_GAIN = 16'd39797;

    // register reset values
    localparam logic [9:0]  LIN_GAIN_RST  = 10'd128;
    localparam logic [9:0]  ANG_GAIN_RST  = 10'd128;
    localparam logic [15:0] DIST_TOL_RST  = 16'd26;
    localparam logic [14:0] HEAD_TOL_RST  = 15'd410;

    typedef enum logic [1:0] {
        REG_LINEAR_GAIN  = 2'd0,
        REG_ANGULAR_GAIN = 2'd1,
        REG_DIST_TOL     = 2'd2,
        REG_HEAD_TOL     = 2'd3
    } cfg_reg_t;

    localparam logic OP_SET_GOAL = 1'b0;
    localparam logic OP_POSE     = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // atan(2^-i) in Q3.20
    function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            5'd20:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/gtg_cordic.sv
// iterative vectoring cordic: one shift-add step per cycle
// depends on gtg_pkg
`default_nettype none

module gtg_cordic
    import gtg_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [DELTA_W-1:0]  dx,
    input  wire logic signed [DELTA_W-1:0]  dy,
    output      cordic_stat_t               stat,
    output      logic signed [DW-1:0]       x_out,
    output      logic signed [ZW-1:0]       z_out
);

    localparam int                IDX_W = $clog2(STEPS);
    localparam logic [IDX_W-1:0]  LAST  = IDX_W'(STEPS - 1);

    logic signed [DW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic                 run_reg, done_reg;

    logic signed [DW-1:0] dx_s, dy_s, xs, ys;
    logic signed [ZW-1:0] at;

    // scale by 2^8 into the datapath width
    assign dx_s = {{(DW-DELTA_W-8){dx[DELTA_W-1]}}, dx, 8'd0};
    assign dy_s = {{(DW-DELTA_W-8){dy[DELTA_W-1]}}, dy, 8'd0};

    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = atan_q20(5'(cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // left half plane: rotate by pi first
            if (dx[DELTA_W-1])
            begin
                x_reg <= -dx_s;
                y_reg <= -dy_s;
                z_reg <= dy[DELTA_W-1] ? -ANG_PI : ANG_PI;
            end
            else
            begin
                x_reg <= dx_s;
                y_reg <= dy_s;
                z_reg <= '0;
            end
        end
        else if (run_reg)
        begin
            if (!y_reg[DW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign x_out     = x_reg;
    assign z_out     = z_reg;

endmodule

`default_nettype wire

// File: sv/go_to_goal_steering.sv
// go-to-goal steering: a set-goal transaction gives no result
// a pose transaction runs the cordic, then S_DIST and S_DEC, and S_FIN loads its result
// the next transaction is accepted only back in idle, after S_FIN has loaded the result
// the cordic does one shift-add iteration per cycle
// plus one shared multiplier used twice; rst_n restores default gains and tolerances
// and clears goal and task
`default_nettype none
`include "go_to_goal_steering_defines.svh"

module go_to_goal_steering
    import gtg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write port
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    // input transaction
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic               op,
    input  wire logic signed [15:0] pose_x,
    input  wire logic signed [15:0] pose_y,
    input  wire logic signed [14:0] pose_heading,
    input  wire logic signed [15:0] goal_x_in,
    input  wire logic signed [15:0] goal_y_in,
    // result transaction
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic [15:0]        linear_speed,
    output      logic signed [15:0] angular_speed,
    output      logic               goal_reached,
    output      logic               turning
);

    // sequencer: idle, wait for cordic, distance multiply, gain multiply, finish
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_VEC  = 5'b00010,
        S_DIST = 5'b00100,
        S_DEC  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [9:0]  lin_gain_reg, ang_gain_reg;
    logic [15:0] dist_tol_reg;
    logic [14:0] head_tol_reg;

    // task state
    logic signed [15:0] goal_x_reg, goal_y_reg;
    logic               armed_reg;

    // per-transaction working registers
    logic signed [14:0] heading_reg;
    logic [18:0]        dist_reg;
    logic signed [17:0] err_reg;
    logic [34:0]        scaled_reg;
    logic               reached_reg, turn_reg;

    // output register
    logic               out_valid_reg;
    logic [15:0]        lin_out_reg;
    logic signed [15:0] ang_out_reg;
    logic               reached_out_reg, turn_out_reg;

    logic in_acc, out_free, out_load, cordic_start;

    logic signed [DELTA_W-1:0] dx, dy;
    cordic_stat_t              cordic_stat;
    logic signed [DW-1:0]      cx;
    logic signed [ZW-1:0]      cz;

    logic [26:0] mul_a;
    logic [15:0] mul_b;
    logic [42:0] mul_p;
    logic [42:0] dist_sum;

    logic signed [ZW:0]  bearing_sum;
    logic signed [16:0]  bearing;
    logic [17:0]         mag;
    logic                reached_c, turn_c;
    logic [15:0]         lin_sat;
    logic signed [15:0]  ang_sat;

    // a new transaction only in idle; a pending result does not block it
    assign in_stall     = (state_reg != S_IDLE);
    assign in_acc       = in_valid && !in_stall;
    assign cordic_start = in_acc && (op == OP_POSE);

    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_FIN) && out_free;

    // goal minus pose, exact in 17 bits
    assign dx = DELTA_W'(goal_x_reg) - DELTA_W'(pose_x);
    assign dy = DELTA_W'(goal_y_reg) - DELTA_W'(pose_y);

    gtg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .dx    (dx),
        .dy    (dy),
        .stat  (cordic_stat),
        .x_out (cx),
        .z_out (cz)
    );

    // bearing rounded from Q3.20 to Q3.12, error against heading
    assign bearing_sum = {cz[ZW-1], cz} + (ZW+1)'(128);
    assign bearing     = bearing_sum[ZW:8];

    // magnitude of the heading error
    assign mag = err_reg[17] ? 18'(-err_reg) : 18'(err_reg);

    assign reached_c = !armed_reg || (dist_reg <= {3'd0, dist_tol_reg});
    assign turn_c    = (mag > {3'd0, head_tol_reg});

    // shared multiplier: cordic magnitude times 1/K, then error or distance times gain
    always_comb
    begin
        mul_a = cx[26:0];
        mul_b = INV_GAIN;
        if (state_reg == S_DEC)
        begin
            if (turn_c)
            begin
                mul_a = {9'd0, mag};
                mul_b = {6'd0, ang_gain_reg};
            end
            else
            begin
                mul_a = {8'd0, dist_reg};
                mul_b = {6'd0, lin_gain_reg};
            end
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign dist_sum = mul_p + (43'd1 << 23);

    // saturation of the scaled products
    assign lin_sat = (|scaled_reg[34:16]) ? 16'hFFFF : scaled_reg[15:0];

    always_comb
    begin
        if (err_reg[17])
        begin
            if (scaled_reg > 35'd32768)
                ang_sat = 16'sh8000;
            else
                ang_sat = 16'(-scaled_reg[15:0]);
        end
        else if (scaled_reg > 35'd32767)
            ang_sat = 16'sh7FFF;
        else
            ang_sat = scaled_reg[15:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (cordic_start) state_next = S_VEC;
            S_VEC:  if (cordic_stat.done) state_next = S_DIST;
            S_DIST: state_next = S_DEC;
            S_DEC:  state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lin_gain_reg  <= LIN_GAIN_RST;
            ang_gain_reg  <= ANG_GAIN_RST;
            dist_tol_reg  <= DIST_TOL_RST;
            head_tol_reg  <= HEAD_TOL_RST;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LINEAR_GAIN:  lin_gain_reg <= cfg_data[9:0];
                    REG_ANGULAR_GAIN: ang_gain_reg <= cfg_data[9:0];
                    REG_DIST_TOL:     dist_tol_reg <= cfg_data;
                    REG_HEAD_TOL:     head_tol_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end

            // set-goal transaction arms the task
            if (in_acc && (op == OP_SET_GOAL))
            begin
                goal_x_reg <= goal_x_in;
                goal_y_reg <= goal_y_in;
                armed_reg  <= 1'b1;
            end
            else if (out_load && reached_reg)
                armed_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cordic_start)
            heading_reg <= pose_heading;

        if (state_reg == S_DIST)
        begin
            dist_reg <= dist_sum[42:24];
            err_reg  <= {bearing[16], bearing} - 18'(heading_reg);
        end

        if (state_reg == S_DEC)
        begin
            scaled_reg  <= mul_p[42:8];
            reached_reg <= reached_c;
            turn_reg    <= turn_c;
        end

        if (out_load)
        begin
            if (reached_reg)
            begin
                lin_out_reg     <= '0;
                ang_out_reg     <= '0;
                reached_out_reg <= 1'b1;
                turn_out_reg    <= 1'b0;
            end
            else if (turn_reg)
            begin
                lin_out_reg     <= '0;
                ang_out_reg     <= ang_sat;
                reached_out_reg <= 1'b0;
                turn_out_reg    <= 1'b1;
            end
            else
            begin
                lin_out_reg     <= lin_sat;
                ang_out_reg     <= '0;
                reached_out_reg <= 1'b0;
                turn_out_reg    <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign linear_speed  = lin_out_reg;
    assign angular_speed = ang_out_reg;
    assign goal_reached  = reached_out_reg;
    assign turning       = turn_out_reg;

    // finishing with a free output register must raise out_valid
    `GTG_ASSERT_NXT(a_fin_loads, clk, rst_n, out_load, out_valid, "result not presented")
    // the cordic only reports completion while the sequencer waits for it
    `GTG_ASSERT_IMP(a_cordic_done, clk, rst_n, cordic_stat.done, state_reg == S_VEC,
                    "stray cordic done")
    // turning and goal reached are exclusive, and turning means no forward speed
    `GTG_ASSERT_IMP(a_turn_excl, clk, rst_n, out_valid && turning,
                    !goal_reached && (linear_speed == 16'd0), "bad turning result")

endmodule

`default_nettype wire

// File: verif/steering_monitor.sv
// monitor and scoreboard for the go-to-goal steering block
// mirrors register writes, predicts each pose command and compares it at the output
// depends on gtg_pkg for register codes, opcodes and reset values
module steering_monitor
    import gtg_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic               op,
    input  wire logic signed [15:0] pose_x,
    input  wire logic signed [15:0] pose_y,
    input  wire logic signed [14:0] pose_heading,
    input  wire logic signed [15:0] goal_x_in,
    input  wire logic signed [15:0] goal_y_in,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [15:0]        linear_speed,
    input  wire logic signed [15:0] angular_speed,
    input  wire logic               goal_reached,
    input  wire logic               turning,
    output int                      mismatch_count,
    output int                      cmds_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0]        lin;
        logic signed [15:0] ang;
        logic               reached;
        logic               turning;
    } steer_cmd_t;

    localparam longint PI_Q20    = 3294199;
    localparam longint INV_K_Q16 = 39797;

    logic [9:0]         lin_gain;
    logic [9:0]         ang_gain;
    logic [15:0]        dist_tol;
    logic [14:0]        head_tol;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic               armed;
    steer_cmd_t         expected_cmds[$];

    initial mismatch_count = 0;
    initial cmds_pending = 0;

    // arctangent of 2^-i in Q3.20
    function automatic longint atan_step(input int i);
        case (i)
            0:       return 823550;
            1:       return 486170;
            2:       return 256879;
            3:       return 130396;
            4:       return 65451;
            5:       return 32757;
            6:       return 16383;
            7:       return 8192;
            8:       return 4096;
            9:       return 2048;
            10:      return 1024;
            11:      return 512;
            12:      return 256;
            13:      return 128;
            14:      return 64;
            15:      return 32;
            16:      return 16;
            17:      return 8;
            18:      return 4;
            19:      return 2;
            20:      return 1;
            default: return 0;
        endcase
    endfunction

    // vectoring cordic: range in Q17.0 and bearing in Q3.12
    function automatic void measure_vector(input longint dx, input longint dy,
                                           output longint range_q8, output longint bearing_q12);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q20 : -PI_Q20;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
            else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
        end
        range_q8    = (x * INV_K_Q16 + 64'sd8388608) >>> 24;
        bearing_q12 = (z + 128) >>> 8;
    endfunction

    function automatic steer_cmd_t steering_command(input logic signed [15:0] px,
                                                    input logic signed [15:0] py,
                                                    input logic signed [14:0] hd);
        steer_cmd_t cmd;
        longint     range_q8;
        longint     bearing_q12;
        longint     err;
        longint     mag;
        longint     ang;
        longint     lin;
        measure_vector(longint'(target_x) - longint'(px), longint'(target_y) - longint'(py),
                       range_q8, bearing_q12);
        err = bearing_q12 - longint'(hd);
        cmd = '0;
        if (!armed || range_q8 <= longint'(dist_tol)) begin
            cmd.reached = 1'b1;
            return cmd;
        end
        mag = (err < 0) ? -err : err;
        if (mag > longint'(head_tol)) begin
            ang = (mag * longint'(ang_gain)) >>> 8;
            if (err < 0) begin
                ang = -ang;
                if (ang < -32768)
                    ang = -32768;
            end
            else if (ang > 32767) begin
                ang = 32767;
            end
            cmd.ang     = ang[15:0];
            cmd.turning = 1'b1;
        end
        else begin
            lin = (range_q8 * longint'(lin_gain)) >>> 8;
            if (lin > 65535)
                lin = 65535;
            cmd.lin = lin[15:0];
        end
        return cmd;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        steer_cmd_t want;
        if (!rst_n) begin
            lin_gain = LIN_GAIN_RST;
            ang_gain = ANG_GAIN_RST;
            dist_tol = DIST_TOL_RST;
            head_tol = HEAD_TOL_RST;
            target_x = '0;
            target_y = '0;
            armed    = 1'b0;
            expected_cmds.delete();
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch($sformatf("unexpected command lin=%0d ang=%0d reached=%0b",
                                              linear_speed, angular_speed, goal_reached));
                end
                else begin
                    want = expected_cmds.pop_front();
                    if (linear_speed !== want.lin)
                        report_mismatch($sformatf("linear_speed %0d, expected %0d",
                                                  linear_speed, want.lin));
                    if (angular_speed !== want.ang)
                        report_mismatch($sformatf("angular_speed %0d, expected %0d",
                                                  angular_speed, want.ang));
                    if (goal_reached !== want.reached)
                        report_mismatch($sformatf("goal_reached %0b, expected %0b",
                                                  goal_reached, want.reached));
                    if (turning !== want.turning)
                        report_mismatch($sformatf("turning %0b, expected %0b",
                                                  turning, want.turning));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_LINEAR_GAIN:  lin_gain = cfg_data[9:0];
                    REG_ANGULAR_GAIN: ang_gain = cfg_data[9:0];
                    REG_DIST_TOL:     dist_tol = cfg_data;
                    REG_HEAD_TOL:     head_tol = cfg_data[14:0];
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall) begin
                if (op == OP_SET_GOAL) begin
                    target_x = goal_x_in;
                    target_y = goal_y_in;
                    armed    = 1'b1;
                end
                else begin
                    want = steering_command(pose_x, pose_y, pose_heading);
                    if (want.reached)
                        armed = 1'b0;
                    expected_cmds.push_back(want);
                end
            end
        end
        cmds_pending = expected_cmds.size();
    end

endmodule

// File: verif/tb.sv
// top of the go-to-goal steering testbench: clock, reset, stimulus and verdict
// drives goal and pose transactions with random idling and back-pressure
// depends on gtg_pkg, go_to_goal_steering and steering_monitor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gtg_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 500000;
    // cordic pass plus multiplier and output stage, with margin
    localparam int DRAIN_CYCLES = 2 * CORDIC_STEPS_DEF + 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 140;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [14:0] pose_heading;
    logic signed [15:0] goal_x_in;
    logic signed [15:0] goal_y_in;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        linear_speed;
    logic signed [15:0] angular_speed;
    logic               goal_reached;
    logic               turning;

    int                 mismatch_count;
    int                 cmds_pending;
    int unsigned        cycle_count = 0;

    // idling controls of the sender and of the receiver process
    bit                 tx_quiet = 1'b0;
    bit                 rx_quiet = 1'b0;
    int                 hold_reqs = 0;
    int                 holds_done = 0;

    // goal most recently sent, used to aim poses near it
    logic signed [15:0] cur_goal_x = '0;
    logic signed [15:0] cur_goal_y = '0;

    go_to_goal_steering u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .pose_x        (pose_x),
        .pose_y        (pose_y),
        .pose_heading  (pose_heading),
        .goal_x_in     (goal_x_in),
        .goal_y_in     (goal_y_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .linear_speed  (linear_speed),
        .angular_speed (angular_speed),
        .goal_reached  (goal_reached),
        .turning       (turning)
    );

    steering_monitor u_mon (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .pose_x         (pose_x),
        .pose_y         (pose_y),
        .pose_heading   (pose_heading),
        .goal_x_in      (goal_x_in),
        .goal_y_in      (goal_y_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .linear_speed   (linear_speed),
        .angular_speed  (angular_speed),
        .goal_reached   (goal_reached),
        .turning        (turning),
        .mismatch_count (mismatch_count),
        .cmds_pending   (cmds_pending)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stall bursts, a long hold on request, none when quiet
    initial begin
        int burst;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_reqs != holds_done) begin
                // long hold so the block backs up and stalls its input
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end
            else if (rx_quiet) begin
                out_stall <= 1'b0;
            end
            else begin
                burst = $urandom_range(1, 16);
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (burst - 1) @(negedge clk);
            end
        end
    end

    // sender drops valid; n sets how long it stays low
    task automatic idle_sender(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // one input transaction, held until accepted, then maybe a gap
    task automatic drive_item(input logic o, input logic [15:0] px, input logic [15:0] py,
                              input logic [14:0] hd, input logic [15:0] gx,
                              input logic [15:0] gy);
        @(negedge clk);
        op           <= o;
        pose_x       <= px;
        pose_y       <= py;
        pose_heading <= hd;
        goal_x_in    <= gx;
        goal_y_in    <= gy;
        in_valid     <= 1'b1;
        if (o == OP_SET_GOAL) begin
            cur_goal_x = gx;
            cur_goal_y = gy;
        end
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!tx_quiet && $urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 16));
    endtask

    // pose fields are don't-care on a goal transaction, so they get noise
    task automatic send_goal(input int gx, input int gy);
        drive_item(OP_SET_GOAL, 16'($urandom), 16'($urandom), 15'($urandom), 16'(gx), 16'(gy));
    endtask

    task automatic send_pose(input int px, input int py, input int hd);
        drive_item(OP_POSE, 16'(px), 16'(py), 15'(hd), 16'($urandom), 16'($urandom));
    endtask

    // pose near the current goal or anywhere, heading often aimed at the goal
    task automatic random_pose();
        int span;
        int px;
        int py;
        int dxi;
        int dyi;
        int hd;
        case ($urandom_range(0, 3))
            0:       span = 48;
            1:       span = 512;
            2:       span = 8192;
            default: span = 0;
        endcase
        if (span == 0) begin
            px = int'($signed(16'($urandom)));
            py = int'($signed(16'($urandom)));
        end
        else begin
            px = int'($signed(16'(int'(cur_goal_x) + int'($urandom_range(0, 2 * span)) - span)));
            py = int'($signed(16'(int'(cur_goal_y) + int'($urandom_range(0, 2 * span)) - span)));
        end
        dxi = int'(cur_goal_x) - px;
        dyi = int'(cur_goal_y) - py;
        if ($urandom_range(0, 2) != 0) begin
            hd = $rtoi($atan2(real'(dyi), real'(dxi)) * 4096.0)
                 + int'($urandom_range(0, 1200)) - 600;
            if (hd > 16383)
                hd = 16383;
            if (hd < -16384)
                hd = -16384;
        end
        else begin
            hd = int'($urandom_range(0, 32767)) - 16384;
        end
        send_pose(px, py, hd);
    endtask

    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // wait for every command, then give the block time to go idle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (cmds_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // unused upper bits carry noise, the block must mask them
    task automatic apply_settings(input int unsigned lg, input int unsigned ag,
                                  input int unsigned dt, input int unsigned ht);
        settle();
        write_reg(REG_LINEAR_GAIN, {6'($urandom), 10'(lg)});
        write_reg(REG_ANGULAR_GAIN, {6'($urandom), 10'(ag)});
        write_reg(REG_DIST_TOL, 16'(dt));
        write_reg(REG_HEAD_TOL, {1'($urandom), 15'(ht)});
    endtask

    initial begin
        int          sent;
        int          n;
        int unsigned lg;
        int unsigned ag;
        int unsigned dt;
        int unsigned ht;
        bit          paused;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        op           = OP_POSE;
        pose_x       = '0;
        pose_y       = '0;
        pose_heading = '0;
        goal_x_in    = '0;
        goal_y_in    = '0;
        paused       = 1'b0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // directed part, reset settings first
        send_pose(100, -100, 0);                  // no task after reset
        send_goal(0, 0);
        send_pose(0, 0, 0);                       // pose exactly on goal
        send_pose(5, 5, 0);                       // disarmed by the previous pose
        send_goal(32767, 32767);
        send_pose(-32768, -32768, 12868);         // turn, negative error
        send_pose(-32768, -32768, -12868);        // turn, positive error
        send_pose(-32768, -32768, 3217);          // roughly on bearing, drive
        send_goal(-32768, 32767);
        send_pose(32767, -32768, 0);              // goal behind, upper half
        send_goal(-32768, -32768);
        send_pose(32767, 32767, 16383);           // goal behind, lower half, heading off range
        send_pose(32767, 32767, -16384);
        send_goal(1000, -2000);
        send_pose(1000, 0, 0);                    // straight below
        send_pose(-500, -2000, 0);                // straight ahead, drive
        send_pose(3000, -2000, 0);                // straight behind

        // saturation of the turn rate in both directions
        apply_settings(1023, 1023, 0, 0);
        send_goal(32767, 32767);
        send_pose(-32768, -32768, -16384);
        send_pose(-32768, -32768, 16383);
        // saturation of the forward speed
        apply_settings(1023, 1023, 0, 32767);
        send_pose(-32768, -32768, 0);
        // widest tolerance still misses the farthest goal, zero gains
        apply_settings(0, 0, 65535, 0);
        send_pose(-32768, -32768, 0);
        send_goal(0, 0);
        send_pose(10, 10, 0);

        // random part: episodes of one goal and several poses, plus noise
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin lg = 128; ag = 128; dt = 26; ht = 410; end
                1: begin lg = 1023; ag = 1023; dt = 0; ht = 0; end
                2: begin lg = 0; ag = 0; dt = 0; ht = 32767; end
                3: begin lg = 1023; ag = 1023; dt = 65535; ht = 32767; end
                NUM_PHASES - 1: begin lg = 256; ag = 256; dt = 26; ht = 410; end
                default: begin
                    lg = $urandom_range(0, 1023);
                    ag = $urandom_range(0, 1023);
                    dt = $urandom_range(0, 1500);
                    ht = $urandom_range(0, 2500);
                end
            endcase
            apply_settings(lg, ag, dt, ht);
            if (ph == NUM_PHASES - 1) begin
                // closing stretch runs at full rate
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            if (ph == 4)
                hold_reqs++;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    drive_item(1'($urandom), 16'($urandom), 16'($urandom), 15'($urandom),
                               16'($urandom), 16'($urandom));
                    sent++;
                end
                else begin
                    send_goal(pick_coord(), pick_coord());
                    n = $urandom_range(1, 12);
                    repeat (n) random_pose();
                    sent += n + 1;
                end
                if (ph == 6 && !paused && sent > 60) begin
                    // sender stops until the block has delivered everything
                    paused = 1'b1;
                    idle_sender(1);
                    while (cmds_pending != 0)
                        @(posedge clk);
                end
            end
        end

        // drain and watch for stray commands
        idle_sender(1);
        while (cmds_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
